// ===== src/jht_pkg.sv =====
// Shared types and codes for the job hash table with active queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package jht_pkg;

  // Operation codes carried in the opcode field of an input item
  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_LOOKUP     = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_ACTIVATE   = 3'd3;
  localparam logic [2:0] OP_POP        = 3'd4;
  localparam logic [2:0] OP_DEACTIVATE = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_PRESENT        = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND      = 3'd2;
  localparam logic [2:0] ST_ACTIVE_REFUSED = 3'd3;
  localparam logic [2:0] ST_BUCKET_FULL    = 3'd4;
  localparam logic [2:0] ST_QUEUE_EMPTY    = 3'd5;
  localparam logic [2:0] ST_QUEUE_FULL     = 3'd6;

  // Golden-ratio multiplier for the bucket hash
  localparam logic [31:0] HASH_MULT = 32'h61C88647;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key_addr;
    logic [3:0]  job_state_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [3:0]  job_state_out;
    logic        active_out;
    logic [31:0] addr_out;
  } out_item_t;

  // One way of a bucket row
  typedef struct packed {
    logic        valid;
    logic        active;
    logic [3:0]  state;
    logic [31:0] key;
  } way_t;

  // Kind of bucket row write
  typedef enum logic [2:0] {
    RW_NONE,
    RW_INSERT,
    RW_REMOVE,
    RW_SET_ACT,
    RW_CLR_ACT,
    RW_CLEAR
  } row_wr_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       hash;
    logic       eval;
    row_wr_t    row_wr;
    logic       clr_step;
    logic       q_append;
    logic       q_pop;
    logic       q_next;
    logic       q_shift;
    logic       q_dec;
    logic       res_load;
    logic [2:0] res_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic hit_act;
    logic full;
    logic q_empty;
    logic q_full;
    logic q_match;
    logic q_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// ===== src/jht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module jht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/jht_ctrl.sv =====
// Controller state machine for the job hash table: sequences each item.
// Depends on jht_pkg for opcodes, status codes and the command/status structs.
module jht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_opcode,
  output logic           in_stall,
  output jht_pkg::cmd_t  cmd,
  input  jht_pkg::stat_t stat
);
  import jht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ROW_RD,
    S_EVAL,
    S_DECIDE,
    S_Q_RD,
    S_Q_CMP,
    S_C_RD,
    S_C_WR,
    S_P_RD,
    S_P_DAT,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [2:0] code_r, code_nxt;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    code_nxt       = code_r;
    cmd            = '0;
    cmd.row_wr     = RW_NONE;
    cmd.res_status = code_r;
    unique case (state_r)
      S_CLEAR: begin
        // sweep the bucket rows to empty after reset
        cmd.row_wr   = RW_CLEAR;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          op_nxt        = in_opcode;
          unique case (in_opcode) inside
            OP_INSERT, OP_LOOKUP, OP_REMOVE, OP_ACTIVATE, OP_DEACTIVATE: begin
              state_nxt = S_HASH;
            end
            OP_POP: begin
              if (stat.q_empty) begin
                code_nxt  = ST_QUEUE_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_P_RD;
              end
            end
            default: begin
              code_nxt  = ST_NOT_FOUND;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_P_RD: begin
        state_nxt = S_P_DAT;
      end
      S_P_DAT: begin
        // take the head key, then look it up in the table
        cmd.q_pop = 1'b1;
        state_nxt = S_HASH;
      end
      S_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = S_ROW_RD;
      end
      S_ROW_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        unique case (op_r)
          OP_INSERT: begin
            if (stat.hit) begin
              code_nxt = ST_PRESENT;
            end else if (stat.full) begin
              code_nxt = ST_BUCKET_FULL;
            end else begin
              cmd.row_wr = RW_INSERT;
              code_nxt   = ST_OK;
            end
          end
          OP_LOOKUP: begin
            code_nxt = stat.hit ? ST_OK : ST_NOT_FOUND;
          end
          OP_REMOVE: begin
            if (!stat.hit) begin
              code_nxt = ST_NOT_FOUND;
            end else if (stat.hit_act) begin
              code_nxt = ST_ACTIVE_REFUSED;
            end else begin
              cmd.row_wr = RW_REMOVE;
              code_nxt   = ST_OK;
            end
          end
          OP_ACTIVATE: begin
            if (!stat.hit) begin
              code_nxt = ST_NOT_FOUND;
            end else if (stat.q_full) begin
              code_nxt = ST_QUEUE_FULL;
            end else begin
              cmd.q_append = 1'b1;
              cmd.row_wr   = RW_SET_ACT;
              code_nxt     = ST_OK;
            end
          end
          OP_POP: begin
            code_nxt = ST_OK;
          end
          OP_DEACTIVATE: begin
            if (stat.q_empty) begin
              code_nxt = ST_NOT_FOUND;
            end else begin
              state_nxt = S_Q_RD;
            end
          end
          default: begin
            code_nxt = ST_NOT_FOUND;
          end
        endcase
      end
      S_Q_RD: begin
        state_nxt = S_Q_CMP;
      end
      S_Q_CMP: begin
        // compare one queued key; on a match close the gap behind it
        if (stat.q_match) begin
          if (stat.q_last) begin
            cmd.q_dec = 1'b1;
            if (stat.hit) begin
              cmd.row_wr = RW_CLR_ACT;
            end
            code_nxt  = ST_OK;
            state_nxt = S_DONE;
          end else begin
            cmd.q_next = 1'b1;
            state_nxt  = S_C_RD;
          end
        end else if (stat.q_last) begin
          code_nxt  = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          cmd.q_next = 1'b1;
          state_nxt  = S_Q_RD;
        end
      end
      S_C_RD: begin
        state_nxt = S_C_WR;
      end
      S_C_WR: begin
        // move one key down a slot
        cmd.q_shift = 1'b1;
        if (stat.q_last) begin
          cmd.q_dec = 1'b1;
          if (stat.hit) begin
            cmd.row_wr = RW_CLR_ACT;
          end
          code_nxt  = ST_OK;
          state_nxt = S_DONE;
        end else begin
          cmd.q_next = 1'b1;
          state_nxt  = S_C_RD;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r    <= '0;
      code_r  <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("controller stayed ready after taking an item");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> stat.out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule

// ===== src/jht_datapath.sv =====
// Datapath for the job hash table: hash, bucket row RAM, active queue RAM,
// match logic and output register. Depends on jht_pkg and jht_ram.
module jht_datapath #(
  parameter int BUCKETS     = 64,
  parameter int WAYS        = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  jht_pkg::in_item_t   in_item,
  output jht_pkg::out_item_t  out_item,
  output logic                out_valid,
  input  logic                out_stall,
  input  jht_pkg::cmd_t       cmd,
  output jht_pkg::stat_t      stat
);
  import jht_pkg::*;

  localparam int HB  = $clog2(BUCKETS);
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW  = WAYS * $bits(way_t);
  localparam int QA  = $clog2(QUEUE_DEPTH);
  localparam int QA1 = QA + 1;
  localparam int QC  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [HB-1:0] BMASK = HB'(BUCKETS - 1);

  // Item and hash registers
  logic [31:0] key_r;
  logic [3:0]  js_r;
  logic [31:0] prod_r;
  logic [31:0] addr_r;
  logic [HB-1:0] bucket;

  // Bucket row match registers
  way_t [WAYS-1:0] row_r, row_rdata, row_wdata;
  logic            row_we;
  logic [HB-1:0]   row_waddr;
  logic            hit_c, free_c;
  logic [WW-1:0]   hit_way_c, free_way_c;
  logic            hit_r, full_r, hit_act_r;
  logic [WW-1:0]   hit_way_r, free_way_r;
  logic [3:0]      hit_state_r;
  logic [HB-1:0]   clr_idx_r;

  // Active queue
  logic [QA-1:0] q_head_r, q_idx_r;
  logic [QC-1:0] q_count_r;
  logic [QA-1:0] q_rd_addr, q_tail, q_prev, q_waddr;
  logic [31:0]   q_rdata, q_wdata;
  logic          q_we;

  // Output register
  logic      out_valid_r;
  out_item_t out_item_r;

  // Wrap a queue position sum back into the ring
  function automatic logic [QA-1:0] qwrap(input logic [QA:0] s);
    logic [QA:0] d;
    d = s - QA1'(QUEUE_DEPTH);
    if (s >= QA1'(QUEUE_DEPTH)) begin
      return d[QA-1:0];
    end
    return s[QA-1:0];
  endfunction

  // Bucket from the top bits of the hash product
  assign bucket = prod_r[31 -: HB] & BMASK;

  jht_ram #(.WIDTH(RW), .DEPTH(BUCKETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (bucket),
    .rdata (row_rdata)
  );

  // Match the key across the ways; lowest way wins
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_way_c  = '0;
    free_way_c = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rdata[w].valid && (row_rdata[w].key == key_r)) begin
        hit_c     = 1'b1;
        hit_way_c = WW'(w);
      end
      if (!row_rdata[w].valid) begin
        free_c     = 1'b1;
        free_way_c = WW'(w);
      end
    end
  end

  // Build the row write
  always_comb begin
    row_wdata = row_r;
    row_waddr = bucket;
    row_we    = 1'b1;
    unique case (cmd.row_wr)
      RW_INSERT: begin
        row_wdata[free_way_r].valid  = 1'b1;
        row_wdata[free_way_r].active = 1'b0;
        row_wdata[free_way_r].state  = js_r;
        row_wdata[free_way_r].key    = key_r;
      end
      RW_REMOVE: begin
        row_wdata[hit_way_r].valid = 1'b0;
      end
      RW_SET_ACT: begin
        row_wdata[hit_way_r].active = 1'b1;
      end
      RW_CLR_ACT: begin
        row_wdata[hit_way_r].active = 1'b0;
      end
      RW_CLEAR: begin
        row_wdata = '0;
        row_waddr = clr_idx_r;
      end
      default: begin
        row_we = 1'b0;
      end
    endcase
  end

  // Item, hash and match registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_r       <= in_item.key_addr;
      js_r        <= in_item.job_state_in;
      addr_r      <= '0;
      hit_r       <= 1'b0;
      hit_state_r <= '0;
      hit_act_r   <= 1'b0;
    end else begin
      if (cmd.q_pop) begin
        key_r  <= q_rdata;
        addr_r <= q_rdata;
      end
      if (cmd.eval) begin
        row_r       <= row_rdata;
        hit_r       <= hit_c;
        hit_way_r   <= hit_way_c;
        free_way_r  <= free_way_c;
        full_r      <= !free_c;
        hit_state_r <= hit_c ? row_rdata[hit_way_c].state : 4'd0;
        hit_act_r   <= hit_c ? row_rdata[hit_way_c].active : 1'b0;
      end
      if (cmd.row_wr == RW_SET_ACT) begin
        hit_act_r <= 1'b1;
      end else if (cmd.row_wr == RW_CLR_ACT) begin
        hit_act_r <= 1'b0;
      end
    end
    if (cmd.hash) begin
      prod_r <= key_r * HASH_MULT;
    end
  end

  // Queue addressing
  assign q_rd_addr = qwrap({1'b0, q_head_r} + {1'b0, q_idx_r});
  assign q_tail    = qwrap({1'b0, q_head_r} + QA1'(q_count_r));
  assign q_prev    = (q_rd_addr == '0) ? QA'(QUEUE_DEPTH - 1) : q_rd_addr - QA'(1);
  assign q_we      = cmd.q_append || cmd.q_shift;
  assign q_waddr   = cmd.q_append ? q_tail : q_prev;
  assign q_wdata   = cmd.q_append ? key_r : q_rdata;

  jht_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_rd_addr),
    .rdata (q_rdata)
  );

  // Queue pointers, clear counter and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r    <= '0;
      q_count_r   <= '0;
      q_idx_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        q_idx_r <= '0;
      end else if (cmd.q_next) begin
        q_idx_r <= q_idx_r + QA'(1);
      end
      if (cmd.q_append) begin
        q_count_r <= q_count_r + QC'(1);
      end else if (cmd.q_pop || cmd.q_dec) begin
        q_count_r <= q_count_r - QC'(1);
      end
      if (cmd.q_pop) begin
        q_head_r <= qwrap({1'b0, q_head_r} + QA1'(1));
      end
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + HB'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item_r.status        <= cmd.res_status;
      out_item_r.found         <= hit_r;
      out_item_r.job_state_out <= hit_state_r;
      out_item_r.active_out    <= hit_act_r;
      out_item_r.addr_out      <= addr_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Status to the controller
  assign stat.hit      = hit_r;
  assign stat.hit_act  = hit_act_r;
  assign stat.full     = full_r;
  assign stat.q_empty  = (q_count_r == '0);
  assign stat.q_full   = (q_count_r == QC'(QUEUE_DEPTH));
  assign stat.q_match  = (q_rdata == key_r);
  assign stat.q_last   = ((QC'(q_idx_r) + QC'(1)) == q_count_r);
  assign stat.clr_last = (clr_idx_r == HB'(BUCKETS - 1));
  assign stat.out_free = !out_valid_r || !out_stall;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QC'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.row_wr == RW_INSERT) |-> (!full_r && !hit_r))
    else $error("insert into a full bucket or over a present key");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_pop |-> (q_count_r != '0))
    else $error("pop from an empty queue");
`endif

endmodule

// ===== src/job_hash_table_with_active_queue.sv =====
// Top level of the job hash table with active queue.
// Depends on jht_pkg, jht_ctrl, jht_datapath (which holds the jht_ram instances).
//
//   channel  ports                          payload
//   input    in_valid, in_stall, in_item    jht_pkg::in_item_t
//   result   out_valid, out_stall, out_item jht_pkg::out_item_t
//
// Insert, lookup, remove and activate go through hash multiply, bucket row RAM read,
// way match, update and result. Pop reads the head from the queue RAM first; pop on
// an empty queue and the unused opcodes go straight to the result. Deactivate also
// scans queue slots up to the match and moves each slot behind it down one.
// After reset a clearing pass empties the rows with in_stall high.
// An item is taken while a result waits on out_stall; its result holds until that one goes.
module job_hash_table_with_active_queue #(
  parameter int BUCKETS     = 64,
  parameter int WAYS        = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jht_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output jht_pkg::out_item_t out_item
);
  import jht_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  jht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_item.opcode),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  jht_datapath #(
    .BUCKETS     (BUCKETS),
    .WAYS        (WAYS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for job_hash_table_with_active_queue: directed and random
// table and queue operations, checked item by item against an in-bench job table.
// Depends on jht_pkg and the job_hash_table_with_active_queue RTL.
`timescale 1ns / 100ps

module tb_top;
  import jht_pkg::*;

  localparam int BUCKETS      = 64;
  localparam int WAYS         = 4;
  localparam int QUEUE_DEPTH  = 16;
  localparam int SLOTS        = BUCKETS * WAYS;
  localparam int HASH_BITS    = $clog2(BUCKETS);
  localparam int POOL_SIZE    = 24;
  localparam int PHASE_ITEMS  = 480;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_PRINTED  = 40;

  // Opcodes the block does not define
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Handshake pacing of the random phases
  typedef enum logic [1:0] {
    PACE_RX_SLOW,
    PACE_TX_SLOW,
    PACE_FULL
  } pace_t;

  // Job table and active queue as the block should hold them
  class job_table_scoreboard;
    bit          slot_used[SLOTS];
    logic [31:0] slot_key[SLOTS];
    logic [3:0]  slot_state[SLOTS];
    bit          slot_active[SLOTS];
    logic [31:0] active_queue[$];
    out_item_t   expected_results[$];
    int          mismatches;
    int          requests;
    int          results;
    int          status_seen[8];

    function int bucket_of(logic [31:0] key);
      logic [31:0] product;
      product = key * HASH_MULT;
      return int'((product >> (32 - HASH_BITS)) & (BUCKETS - 1));
    endfunction

    // Lowest way of the key's bucket that holds the key, or -1
    function int find_job(logic [31:0] key);
      int base;
      int hit;
      base = bucket_of(key) * WAYS;
      hit  = -1;
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (slot_used[base + w] && slot_key[base + w] == key) hit = base + w;
      end
      return hit;
    endfunction

    function void show_entry(inout out_item_t res, input int slot);
      if (slot >= 0) begin
        res.found         = 1'b1;
        res.job_state_out = slot_state[slot];
        res.active_out    = slot_active[slot];
      end
    endfunction

    // Apply one accepted item to the table and queue the result it must give
    function void note_request(in_item_t req);
      out_item_t   res;
      int          slot;
      int          base;
      int          pos;
      bit          placed;
      logic [31:0] head;
      res        = '0;
      res.status = ST_NOT_FOUND;
      slot       = find_job(req.key_addr);
      base       = bucket_of(req.key_addr) * WAYS;
      requests++;
      case (req.opcode)
        OP_INSERT: begin
          if (slot >= 0) begin
            res.status = ST_PRESENT;
            show_entry(res, slot);
          end else begin
            res.status = ST_BUCKET_FULL;
            placed     = 1'b0;
            for (int w = 0; w < WAYS; w++) begin
              if (!placed && !slot_used[base + w]) begin
                slot_used[base + w]   = 1'b1;
                slot_key[base + w]    = req.key_addr;
                slot_state[base + w]  = req.job_state_in;
                slot_active[base + w] = 1'b0;
                res.status            = ST_OK;
                placed                = 1'b1;
              end
            end
          end
        end
        OP_LOOKUP: begin
          if (slot >= 0) begin
            res.status = ST_OK;
            show_entry(res, slot);
          end
        end
        OP_REMOVE: begin
          if (slot >= 0 && slot_active[slot]) begin
            res.status = ST_ACTIVE_REFUSED;
            show_entry(res, slot);
          end else if (slot >= 0) begin
            res.status = ST_OK;
            show_entry(res, slot);
            slot_used[slot] = 1'b0;
          end
        end
        OP_ACTIVATE: begin
          if (slot >= 0 && active_queue.size() >= QUEUE_DEPTH) begin
            res.status = ST_QUEUE_FULL;
            show_entry(res, slot);
          end else if (slot >= 0) begin
            active_queue.push_back(req.key_addr);
            slot_active[slot] = 1'b1;
            res.status        = ST_OK;
            show_entry(res, slot);
          end
        end
        OP_POP: begin
          if (active_queue.size() == 0) begin
            res.status = ST_QUEUE_EMPTY;
          end else begin
            head         = active_queue.pop_front();
            res.status   = ST_OK;
            res.addr_out = head;
            show_entry(res, find_job(head));
          end
        end
        OP_DEACTIVATE: begin
          pos = -1;
          for (int i = active_queue.size() - 1; i >= 0; i--) begin
            if (active_queue[i] == req.key_addr) pos = i;
          end
          if (pos >= 0) begin
            active_queue.delete(pos);
            if (slot >= 0) slot_active[slot] = 1'b0;
            res.status = ST_OK;
          end
          show_entry(res, slot);
        end
        default: begin
          // spare opcodes: not_found and nothing else
        end
      endcase
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d", got.status));
      end else begin
        want = expected_results.pop_front();
        results++;
        status_seen[want.status]++;
        if (got.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results, got.status, want.status));
        if (got.found !== want.found)
          report_mismatch($sformatf("result %0d found %0b, want %0b",
                                    results, got.found, want.found));
        if (got.job_state_out !== want.job_state_out)
          report_mismatch($sformatf("result %0d job_state_out %0d, want %0d",
                                    results, got.job_state_out, want.job_state_out));
        if (got.active_out !== want.active_out)
          report_mismatch($sformatf("result %0d active_out %0b, want %0b",
                                    results, got.active_out, want.active_out));
        if (got.addr_out !== want.addr_out)
          report_mismatch($sformatf("result %0d addr_out %h, want %h",
                                    results, got.addr_out, want.addr_out));
      end
    endtask

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  pace_t       pace      = PACE_RX_SLOW;
  logic        hold_go   = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          random_sent;
  logic [31:0] key_pool[POOL_SIZE];
  job_table_scoreboard sb;

  job_hash_table_with_active_queue #(
    .BUCKETS     (BUCKETS),
    .WAYS        (WAYS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  // Abort on a run that never finishes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.outstanding());
      $display("job_hash_table_with_active_queue test failed");
      $finish;
    end
  end

  // Result side: check accepted items, stall at random or for one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (pace)
          PACE_RX_SLOW: out_stall <= ($urandom_range(99) < 65);
          PACE_TX_SLOW: out_stall <= ($urandom_range(99) < 22);
          default:      out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Offer one item after a random gap; valid stays high once it is taken
  task automatic send_item(input logic [2:0] op, input logic [31:0] key,
                           input logic [3:0] job_state);
    int       idle_pct;
    in_item_t req;
    idle_pct = (pace == PACE_RX_SLOW) ? 22 : (pace == PACE_TX_SLOW) ? 65 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req.opcode       = op;
    req.key_addr     = key;
    req.job_state_in = job_state;
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  // Drop valid and hold off until every expected result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Mostly keys from the pool, now and then any address
  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 88) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_opcode();
    int roll;
    roll = $urandom_range(99);
    if (roll < 22) return OP_INSERT;
    if (roll < 34) return OP_LOOKUP;
    if (roll < 48) return OP_REMOVE;
    if (roll < 70) return OP_ACTIVATE;
    if (roll < 84) return OP_POP;
    if (roll < 98) return OP_DEACTIVATE;
    return (roll == 98) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  task automatic send_random();
    send_item(pick_opcode(), pick_key(), 4'($urandom_range(15)));
    random_sent++;
  endtask

  task automatic send_counted(input logic [2:0] op, input logic [31:0] key);
    send_item(op, key, 4'($urandom_range(15)));
    random_sent++;
  endtask

  // Life of one job: insert, activate, retire from the queue, remove
  task automatic run_job_life();
    logic [31:0] key;
    int          activations;
    int          retire;
    key         = pick_key();
    activations = $urandom_range(1, 3);
    retire      = $urandom_range(2);
    send_counted(OP_INSERT, key);
    if ($urandom_range(1)) send_counted(OP_LOOKUP, key);
    repeat (activations) send_counted(OP_ACTIVATE, key);
    if (retire != 1) send_counted(OP_DEACTIVATE, key);
    if (retire != 0) send_counted(OP_POP, key);
    if ($urandom_range(3) == 0) send_counted(OP_DEACTIVATE, key);
    send_counted(OP_REMOVE, key);
  endtask

  initial begin
    logic [31:0] candidate;
    int          far_bucket;
    sb = new();

    // Key pool: a crowd in bucket zero, a crowd with the all-ones key, then loose keys
    key_pool[0] = 32'h0000_0000;
    key_pool[7] = 32'hFFFF_FFFF;
    far_bucket  = sb.bucket_of(32'hFFFF_FFFF);
    for (int i = 1; i < POOL_SIZE; i++) begin
      if (i != 7) begin
        candidate = $urandom();
        if (i < 7) begin
          while (sb.bucket_of(candidate) != 0) candidate = $urandom();
        end else if (i < 12) begin
          while (sb.bucket_of(candidate) != far_bucket) candidate = $urandom();
        end
        key_pool[i] = candidate;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every status but queue_full, both ends of the key and state, stale queue entries
    send_item(OP_POP,        32'h0000_0000, 4'h0);
    send_item(OP_DEACTIVATE, 32'h0000_0000, 4'h0);
    send_item(OP_LOOKUP,     32'h0000_0000, 4'h0);
    send_item(OP_REMOVE,     32'h0000_0000, 4'h0);
    send_item(OP_ACTIVATE,   32'h0000_0000, 4'h0);
    send_item(OP_INSERT,     32'h0000_0000, 4'h0);
    send_item(OP_INSERT,     32'hFFFF_FFFF, 4'hF);
    send_item(OP_INSERT,     32'h0000_0000, 4'h5);
    send_item(OP_LOOKUP,     32'hFFFF_FFFF, 4'h0);
    for (int i = 1; i <= 4; i++) send_item(OP_INSERT, key_pool[i], 4'(i));
    send_item(OP_ACTIVATE,   32'hFFFF_FFFF, 4'h0);
    send_item(OP_ACTIVATE,   32'hFFFF_FFFF, 4'h0);
    send_item(OP_REMOVE,     32'hFFFF_FFFF, 4'h0);
    send_item(OP_DEACTIVATE, 32'hFFFF_FFFF, 4'h0);
    send_item(OP_REMOVE,     32'hFFFF_FFFF, 4'h0);
    send_item(OP_POP,        32'h0000_0000, 4'h0);
    send_item(OP_ACTIVATE,   32'h0000_0000, 4'h0);
    send_item(OP_POP,        32'hFFFF_FFFF, 4'hF);
    send_item(OP_REMOVE,     32'h0000_0000, 4'h0);
    send_item(OP_SPARE_6,    32'h0000_0000, 4'h0);
    send_item(OP_SPARE_7,    32'hFFFF_FFFF, 4'hF);
    send_item(OP_LOOKUP,     32'h0000_0000, 4'h0);
    wait_for_results();

    // Random: job lives mixed with loose operations, under three pacings
    random_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      pace <= pace_t'(ph);
      if (pace_t'(ph) == PACE_FULL) hold_go <= 1'b1;
      @(posedge clk);
      while (random_sent < PHASE_ITEMS * (ph + 1)) begin
        if ($urandom_range(99) < 55) run_job_life();
        else send_random();
      end
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));

    $display("Run covered %0d items and %0d results: ok %0d, present %0d, not_found %0d,",
             sb.requests, sb.results, sb.status_seen[ST_OK], sb.status_seen[ST_PRESENT],
             sb.status_seen[ST_NOT_FOUND]);
    $display("  active_refused %0d, bucket_full %0d, queue_empty %0d, queue_full %0d.",
             sb.status_seen[ST_ACTIVE_REFUSED], sb.status_seen[ST_BUCKET_FULL],
             sb.status_seen[ST_QUEUE_EMPTY], sb.status_seen[ST_QUEUE_FULL]);
    if (sb.mismatches == 0) begin
      $display("job_hash_table_with_active_queue test passed");
    end else begin
      $display("job_hash_table_with_active_queue test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/jht_pkg.sv
src/jht_ram.sv
src/jht_ctrl.sv
src/jht_datapath.sv
src/job_hash_table_with_active_queue.sv
test/tb_top.sv
